/* rtl/core/csv_byte_tokenizer_defines.svh */
// Assertion macros for the CSV tokenizer RTL (used by csvt_fsm).
// Depends on nothing; included by files that carry assertions.
`ifndef CSV_BYTE_TOKENIZER_DEFINES_SVH
`define CSV_BYTE_TOKENIZER_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define CSVT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("csvt assertion failed");

// Next-cycle implication, disabled in reset.
`define CSVT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("csvt assertion failed");

`endif

/* rtl/core/csvt_pkg.sv */
// Package for the CSV byte tokenizer: character codes, error codes, result word type.
// Depends on nothing; used by the interfaces, csvt_fsm and csv_byte_tokenizer.
`timescale 1ns / 1ps
`default_nettype none

package csvt_pkg;

  localparam int BYTE_W = 8;
  localparam int ERR_W  = 3;

  localparam logic [BYTE_W-1:0] CH_QUOTE = 8'h22;
  localparam logic [BYTE_W-1:0] CH_COMMA = 8'h2C;
  localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;

  localparam logic [ERR_W-1:0] ERR_NONE       = 3'd0;
  localparam logic [ERR_W-1:0] ERR_BLANK_LINE = 3'd1;
  localparam logic [ERR_W-1:0] ERR_BAD_QUOTE  = 3'd2;
  localparam logic [ERR_W-1:0] ERR_LONE_CR    = 3'd3;
  localparam logic [ERR_W-1:0] ERR_UNCLOSED   = 3'd4;

  typedef struct packed {
    logic              char_valid;
    logic [BYTE_W-1:0] char_out;
    logic              field_end;
    logic              row_end;
    logic [ERR_W-1:0]  error_code;
    logic              ignored;
    logic              done_res;
  } res_t;

endpackage

`default_nettype wire

/* rtl/core/csvt_ifs.sv */
// Valid/ready channel interfaces for the CSV tokenizer input and result words.
// Depends on csvt_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface csvt_in_if;
  logic                      valid;
  logic                      ready;
  logic [csvt_pkg::BYTE_W-1:0] byte_value;
  logic                      is_last;

  modport source (output valid, output byte_value, output is_last, input ready);
  modport sink   (input valid, input byte_value, input is_last, output ready);
endinterface

interface csvt_out_if;
  logic                        valid;
  logic                        ready;
  logic                        char_valid;
  logic [csvt_pkg::BYTE_W-1:0] char_out;
  logic                        field_end;
  logic                        row_end;
  logic [csvt_pkg::ERR_W-1:0]  error_code;
  logic                        ignored;
  logic                        done_res;

  modport source (output valid, output char_valid, output char_out, output field_end,
                  output row_end, output error_code, output ignored, output done_res,
                  input ready);
  modport sink   (input valid, input char_valid, input char_out, input field_end,
                  input row_end, input error_code, input ignored, input done_res,
                  output ready);
endinterface

`default_nettype wire

/* rtl/core/csvt_fsm.sv */
// Parse state machine of the CSV tokenizer: next-state decode, end flush, result register.
// Depends on csvt_pkg and csv_byte_tokenizer_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "csv_byte_tokenizer_defines.svh"

module csvt_fsm (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        ld,
  input  wire logic [csvt_pkg::BYTE_W-1:0] byte_i,
  input  wire logic                        last_i,
  output      csvt_pkg::res_t              res_o
);
  import csvt_pkg::*;

  typedef enum logic [2:0] {
    S_START  = 3'd0,
    S_PLAIN  = 3'd1,
    S_QUOTED = 3'd2,
    S_SEP    = 3'd3,
    S_QQ     = 3'd4,
    S_CR     = 3'd5,
    S_ERR    = 3'd6
  } state_t;

  state_t state_r, state_nxt, step_st;
  res_t   res_r, res_nxt;

  always_comb begin
    step_st            = state_r;
    res_nxt            = '0;
    res_nxt.error_code = ERR_NONE;
    res_nxt.done_res   = last_i;
    unique case (state_r)
      S_PLAIN: begin
        case (byte_i)
          CH_COMMA: begin res_nxt.field_end = 1'b1; step_st = S_SEP; end
          CH_CR:    begin res_nxt.field_end = 1'b1; step_st = S_CR; end
          default:  begin res_nxt.char_valid = 1'b1; res_nxt.char_out = byte_i; end
        endcase
      end
      S_QUOTED: begin
        case (byte_i)
          CH_QUOTE: step_st = S_QQ;
          default:  begin res_nxt.char_valid = 1'b1; res_nxt.char_out = byte_i; end
        endcase
      end
      S_SEP: begin
        case (byte_i)
          CH_COMMA: res_nxt.field_end = 1'b1;
          CH_QUOTE: step_st = S_QUOTED;
          CH_CR:    begin res_nxt.field_end = 1'b1; step_st = S_CR; end
          default: begin
            res_nxt.char_valid = 1'b1;
            res_nxt.char_out   = byte_i;
            step_st            = S_PLAIN;
          end
        endcase
      end
      S_QQ: begin
        case (byte_i)
          CH_COMMA: begin res_nxt.field_end = 1'b1; step_st = S_SEP; end
          CH_CR:    begin res_nxt.field_end = 1'b1; step_st = S_CR; end
          CH_QUOTE: begin
            res_nxt.char_valid = 1'b1;
            res_nxt.char_out   = CH_QUOTE;
            step_st            = S_QUOTED;
          end
          default:  begin res_nxt.error_code = ERR_BAD_QUOTE; step_st = S_ERR; end
        endcase
      end
      S_CR: begin
        case (byte_i)
          CH_LF:   begin res_nxt.row_end = 1'b1; step_st = S_START; end
          default: begin res_nxt.error_code = ERR_LONE_CR; step_st = S_ERR; end
        endcase
      end
      S_ERR: res_nxt.ignored = 1'b1;
      default: begin
        case (byte_i) inside
          CH_QUOTE:     step_st = S_QUOTED;
          CH_COMMA:     begin res_nxt.field_end = 1'b1; step_st = S_SEP; end
          CH_CR, CH_LF: begin res_nxt.error_code = ERR_BLANK_LINE; step_st = S_ERR; end
          default: begin
            res_nxt.char_valid = 1'b1;
            res_nxt.char_out   = byte_i;
            step_st            = S_PLAIN;
          end
        endcase
      end
    endcase

    state_nxt = step_st;
    if (last_i) begin
      case (step_st) inside
        S_PLAIN, S_QQ, S_SEP: begin
          res_nxt.field_end = 1'b1;
          res_nxt.row_end   = 1'b1;
        end
        S_QUOTED: res_nxt.error_code = ERR_UNCLOSED;
        default:  ;
      endcase
      state_nxt = S_START;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_START;
    end else if (ld) begin
      state_r <= state_nxt;
      res_r   <= res_nxt;
    end
  end

  assign res_o = res_r;

  `CSVT_ASSERT_NXT(a_last_restarts, clk, rst_n, ld && last_i, state_r == S_START)
  `CSVT_ASSERT_NXT(a_err_sticky, clk, rst_n, ld && !last_i && state_r == S_ERR,
                   state_r == S_ERR && res_r.ignored)
  `CSVT_ASSERT_NXT(a_crlf_row, clk, rst_n, ld && state_r == S_CR && byte_i == CH_LF,
                   res_r.row_end && !res_r.char_valid && res_r.error_code == ERR_NONE)

endmodule

`default_nettype wire

/* rtl/core/csv_byte_tokenizer.sv */
// An accepted byte is held in the input register, then parsed into the result register.
// Throughput: one byte per cycle unless out ready stalls; the registers decouple both sides.
// Backpressure: in ready is high if the input stage is empty or moves into the result register.
// Reset: synchronous, active low; clears the stage valids and returns the parser to field start.
// Depends on csvt_pkg, csvt_ifs and csvt_fsm.
`timescale 1ns / 1ps
`default_nettype none

module csv_byte_tokenizer (
  input wire logic clk,
  input wire logic rst_n,
  csvt_in_if.sink   in_ch,
  csvt_out_if.source out_ch
);
  import csvt_pkg::*;

  logic              s1_valid_r, s1_valid_nxt;
  logic [BYTE_W-1:0] s1_byte_r;
  logic              s1_last_r;
  logic              out_valid_r, out_valid_nxt;
  logic              in_acc, adv;
  res_t              res;

  assign adv           = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready   = !s1_valid_r || adv;
  assign in_acc        = in_ch.valid && in_ch.ready;
  assign s1_valid_nxt  = in_acc || (s1_valid_r && !adv);
  assign out_valid_nxt = adv || (out_valid_r && !out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_byte_r <= in_ch.byte_value;
      s1_last_r <= in_ch.is_last;
    end
  end

  csvt_fsm u_fsm (
    .clk    (clk),
    .rst_n  (rst_n),
    .ld     (adv),
    .byte_i (s1_byte_r),
    .last_i (s1_last_r),
    .res_o  (res)
  );

  assign out_ch.valid      = out_valid_r;
  assign out_ch.char_valid = res.char_valid;
  assign out_ch.char_out   = res.char_out;
  assign out_ch.field_end  = res.field_end;
  assign out_ch.row_end    = res.row_end;
  assign out_ch.error_code = res.error_code;
  assign out_ch.ignored    = res.ignored;
  assign out_ch.done_res   = res.done_res;

endmodule

`default_nettype wire

/* tb/testbench.sv */
// Self-checking testbench for csv_byte_tokenizer: directed table, then random CSV texts.
// Results are checked against table expectations or a local tokenizer model; needs csvt_pkg, csvt_ifs and the RTL.
`timescale 1ns / 1ps

module testbench;
  import csvt_pkg::*;

  localparam int STALL_LIMIT  = 200;
  localparam int RANDOM_BYTES = 750;

  typedef enum logic [2:0] {
    TS_START, TS_PLAIN, TS_QUOTED, TS_SEP, TS_QQ, TS_CR, TS_ERR
  } tok_st_t;

  typedef struct {
    logic [BYTE_W-1:0] data;
    logic              last;
    bit                typed;
    res_t              want;
  } dir_row_t;

  logic clk;
  logic rst_n;

  csvt_in_if  in_bus ();
  csvt_out_if out_bus ();

  csv_byte_tokenizer dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus)
  );

  tok_st_t  tok_state;
  res_t     due_tokens[$];
  dir_row_t dir_tab[$];
  int       mismatches;
  int       idle_cycles;
  bit       tx_calm;
  bit       rx_calm;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic res_t tokenize_byte(input logic [BYTE_W-1:0] b, input logic last);
    res_t    tok;
    tok_st_t nxt;
    tok = '0;
    nxt = tok_state;
    case (tok_state)
      TS_PLAIN: begin
        if (b == CH_COMMA) begin
          tok.field_end = 1'b1;
          nxt = TS_SEP;
        end else if (b == CH_CR) begin
          tok.field_end = 1'b1;
          nxt = TS_CR;
        end else begin
          tok.char_valid = 1'b1;
          tok.char_out = b;
        end
      end
      TS_QUOTED: begin
        if (b == CH_QUOTE) begin
          nxt = TS_QQ;
        end else begin
          tok.char_valid = 1'b1;
          tok.char_out = b;
        end
      end
      TS_SEP: begin
        if (b == CH_COMMA) begin
          tok.field_end = 1'b1;
        end else if (b == CH_QUOTE) begin
          nxt = TS_QUOTED;
        end else if (b == CH_CR) begin
          tok.field_end = 1'b1;
          nxt = TS_CR;
        end else begin
          tok.char_valid = 1'b1;
          tok.char_out = b;
          nxt = TS_PLAIN;
        end
      end
      TS_QQ: begin
        if (b == CH_COMMA) begin
          tok.field_end = 1'b1;
          nxt = TS_SEP;
        end else if (b == CH_CR) begin
          tok.field_end = 1'b1;
          nxt = TS_CR;
        end else if (b == CH_QUOTE) begin
          tok.char_valid = 1'b1;
          tok.char_out = CH_QUOTE;
          nxt = TS_QUOTED;
        end else begin
          tok.error_code = ERR_BAD_QUOTE;
          nxt = TS_ERR;
        end
      end
      TS_CR: begin
        if (b == CH_LF) begin
          tok.row_end = 1'b1;
          nxt = TS_START;
        end else begin
          tok.error_code = ERR_LONE_CR;
          nxt = TS_ERR;
        end
      end
      TS_ERR: begin
        tok.ignored = 1'b1;
      end
      default: begin
        if (b == CH_QUOTE) begin
          nxt = TS_QUOTED;
        end else if (b == CH_COMMA) begin
          tok.field_end = 1'b1;
          nxt = TS_SEP;
        end else if (b == CH_CR || b == CH_LF) begin
          tok.error_code = ERR_BLANK_LINE;
          nxt = TS_ERR;
        end else begin
          tok.char_valid = 1'b1;
          tok.char_out = b;
          nxt = TS_PLAIN;
        end
      end
    endcase
    if (last) begin
      case (nxt)
        TS_PLAIN, TS_QQ, TS_SEP: begin
          tok.field_end = 1'b1;
          tok.row_end = 1'b1;
        end
        TS_QUOTED: begin
          tok.error_code = ERR_UNCLOSED;
        end
        default: ;
      endcase
      nxt = TS_START;
    end
    tok.done_res = last;
    tok_state = nxt;
    return tok;
  endfunction

  function automatic dir_row_t mk_row(input logic [BYTE_W-1:0] b, input logic last,
                                      input bit typed, input logic cv,
                                      input logic [BYTE_W-1:0] co, input logic fe,
                                      input logic re, input logic [ERR_W-1:0] err,
                                      input logic ign, input logic dn);
    dir_row_t row;
    row.data = b;
    row.last = last;
    row.typed = typed;
    row.want.char_valid = cv;
    row.want.char_out = co;
    row.want.field_end = fe;
    row.want.row_end = re;
    row.want.error_code = err;
    row.want.ignored = ign;
    row.want.done_res = dn;
    return row;
  endfunction

  function automatic logic [BYTE_W-1:0] odd_byte();
    case ($urandom_range(0, 4))
      0: return CH_QUOTE;
      1: return CH_COMMA;
      2: return CH_CR;
      3: return CH_LF;
      default: return BYTE_W'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic feed_byte(input logic [BYTE_W-1:0] b, input logic last,
                           input bit typed, input res_t want);
    int   gap;
    res_t tok;
    gap = tx_calm ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.byte_value <= b;
    in_bus.is_last <= last;
    do @(posedge clk); while (!in_bus.ready);
    tok = tokenize_byte(b, last);
    due_tokens = {due_tokens, (typed ? want : tok)};
  endtask

  task automatic drain_wait();
    in_bus.valid <= 1'b0;
    do @(posedge clk); while (due_tokens.size() != 0);
  endtask

  task automatic check_token(input res_t want, input res_t got);
    if (got.char_valid !== want.char_valid) begin
      $error("char_valid: expected %0d, actual %0d", want.char_valid, got.char_valid);
      mismatches++;
    end
    if (got.char_out !== want.char_out) begin
      $error("char_out: expected %0h, actual %0h", want.char_out, got.char_out);
      mismatches++;
    end
    if (got.field_end !== want.field_end) begin
      $error("field_end: expected %0d, actual %0d", want.field_end, got.field_end);
      mismatches++;
    end
    if (got.row_end !== want.row_end) begin
      $error("row_end: expected %0d, actual %0d", want.row_end, got.row_end);
      mismatches++;
    end
    if (got.error_code !== want.error_code) begin
      $error("error_code: expected %0d, actual %0d", want.error_code, got.error_code);
      mismatches++;
    end
    if (got.ignored !== want.ignored) begin
      $error("ignored: expected %0d, actual %0d", want.ignored, got.ignored);
      mismatches++;
    end
    if (got.done_res !== want.done_res) begin
      $error("done_res: expected %0d, actual %0d", want.done_res, got.done_res);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("testbench: FAIL");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin : rx_side
    int   stall;
    res_t got;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if ($urandom_range(0, 63) == 0) rx_calm = !rx_calm;
      stall = rx_calm ? 0 : $urandom_range(0, 4);
      if (stall > 0) begin
        out_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_bus.ready <= 1'b1;
      do @(posedge clk); while (!out_bus.valid);
      got.char_valid = out_bus.char_valid;
      got.char_out = out_bus.char_out;
      got.field_end = out_bus.field_end;
      got.row_end = out_bus.row_end;
      got.error_code = out_bus.error_code;
      got.ignored = out_bus.ignored;
      got.done_res = out_bus.done_res;
      if (due_tokens.size() == 0) begin
        $error("result word with no expectation pending");
        mismatches++;
      end else begin
        check_token(due_tokens.pop_front(), got);
      end
    end
  end

  initial begin : tx_side
    logic [BYTE_W-1:0] text_bytes[$];
    logic [BYTE_W-1:0] b;
    int                sent;
    int                text_idx;
    int                kind;
    int                rows;
    int                fields;
    int                len;
    clk = 1'b0;
    rst_n = 1'b0;
    in_bus.valid = 1'b0;
    in_bus.byte_value = '0;
    in_bus.is_last = 1'b0;
    out_bus.ready = 1'b0;
    tok_state = TS_START;
    mismatches = 0;
    idle_cycles = 0;
    tx_calm = 1'b0;
    rx_calm = 1'b0;
    sent = 0;
    text_idx = 0;

    dir_tab = {dir_tab, mk_row(8'h00, 0, 1, 1, 8'h00, 0, 0, ERR_NONE, 0, 0)};
    dir_tab = {dir_tab, mk_row(8'hFF, 0, 1, 1, 8'hFF, 0, 0, ERR_NONE, 0, 0)};
    dir_tab = {dir_tab, mk_row(CH_COMMA, 0, 0, 0, 0, 0, 0, ERR_NONE, 0, 0)};
    dir_tab = {dir_tab, mk_row(CH_QUOTE, 0, 0, 0, 0, 0, 0, ERR_NONE, 0, 0)};
    dir_tab = {dir_tab, mk_row(8'h78, 0, 0, 0, 0, 0, 0, ERR_NONE, 0, 0)};
    dir_tab = {dir_tab, mk_row(CH_QUOTE, 0, 0, 0, 0, 0, 0, ERR_NONE, 0, 0)};
    dir_tab = {dir_tab, mk_row(CH_QUOTE, 0, 0, 0, 0, 0, 0, ERR_NONE, 0, 0)};
    dir_tab = {dir_tab, mk_row(CH_QUOTE, 0, 0, 0, 0, 0, 0, ERR_NONE, 0, 0)};
    dir_tab = {dir_tab, mk_row(CH_COMMA, 0, 0, 0, 0, 0, 0, ERR_NONE, 0, 0)};
    dir_tab = {dir_tab, mk_row(CH_CR, 0, 0, 0, 0, 0, 0, ERR_NONE, 0, 0)};
    dir_tab = {dir_tab, mk_row(CH_LF, 1, 0, 0, 0, 0, 0, ERR_NONE, 0, 0)};
    dir_tab = {dir_tab, mk_row(CH_CR, 0, 1, 0, 8'h00, 0, 0, ERR_BLANK_LINE, 0, 0)};
    dir_tab = {dir_tab, mk_row(8'hFF, 1, 1, 0, 8'h00, 0, 0, ERR_NONE, 1, 1)};
    dir_tab = {dir_tab, mk_row(CH_QUOTE, 0, 0, 0, 0, 0, 0, ERR_NONE, 0, 0)};
    dir_tab = {dir_tab, mk_row(CH_QUOTE, 0, 0, 0, 0, 0, 0, ERR_NONE, 0, 0)};
    dir_tab = {dir_tab, mk_row(8'h71, 0, 1, 0, 8'h00, 0, 0, ERR_BAD_QUOTE, 0, 0)};
    dir_tab = {dir_tab, mk_row(CH_LF, 1, 1, 0, 8'h00, 0, 0, ERR_NONE, 1, 1)};
    dir_tab = {dir_tab, mk_row(8'h63, 0, 0, 0, 0, 0, 0, ERR_NONE, 0, 0)};
    dir_tab = {dir_tab, mk_row(CH_CR, 0, 0, 0, 0, 0, 0, ERR_NONE, 0, 0)};
    dir_tab = {dir_tab, mk_row(8'h64, 1, 1, 0, 8'h00, 0, 0, ERR_LONE_CR, 0, 1)};
    dir_tab = {dir_tab, mk_row(CH_QUOTE, 0, 0, 0, 0, 0, 0, ERR_NONE, 0, 0)};
    dir_tab = {dir_tab, mk_row(8'h79, 1, 1, 1, 8'h79, 0, 0, ERR_UNCLOSED, 0, 1)};
    dir_tab = {dir_tab, mk_row(CH_COMMA, 1, 0, 0, 0, 0, 0, ERR_NONE, 0, 0)};
    dir_tab = {dir_tab, mk_row(8'h66, 0, 0, 0, 0, 0, 0, ERR_NONE, 0, 0)};
    dir_tab = {dir_tab, mk_row(CH_CR, 1, 0, 0, 0, 0, 0, ERR_NONE, 0, 0)};
    dir_tab = {dir_tab, mk_row(CH_QUOTE, 0, 0, 0, 0, 0, 0, ERR_NONE, 0, 0)};
    dir_tab = {dir_tab, mk_row(CH_QUOTE, 1, 0, 0, 0, 0, 0, ERR_NONE, 0, 0)};

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i]) begin
      feed_byte(dir_tab[i].data, dir_tab[i].last, dir_tab[i].typed, dir_tab[i].want);
    end
    drain_wait();

    while (sent < RANDOM_BYTES) begin
      text_bytes.delete();
      kind = $urandom_range(0, 19);
      if (kind == 0) begin
        repeat ($urandom_range(1, 8)) text_bytes = {text_bytes, odd_byte()};
      end else begin
        rows = $urandom_range(1, 3);
        for (int r = 0; r < rows; r++) begin
          fields = $urandom_range(1, 4);
          for (int f = 0; f < fields; f++) begin
            if (f > 0) text_bytes = {text_bytes, CH_COMMA};
            if ($urandom_range(0, 2) == 0) begin
              text_bytes = {text_bytes, CH_QUOTE};
              len = $urandom_range(0, 5);
              repeat (len) begin
                case ($urandom_range(0, 9))
                  0: begin
                    text_bytes = {text_bytes, CH_QUOTE};
                    text_bytes = {text_bytes, CH_QUOTE};
                  end
                  1: text_bytes = {text_bytes, CH_COMMA};
                  2: text_bytes = {text_bytes, CH_CR};
                  3: text_bytes = {text_bytes, CH_LF};
                  default: begin
                    b = BYTE_W'($urandom_range(0, 255));
                    text_bytes = {text_bytes, b};
                    if (b == CH_QUOTE) text_bytes = {text_bytes, CH_QUOTE};
                  end
                endcase
              end
              text_bytes = {text_bytes, CH_QUOTE};
            end else begin
              len = $urandom_range(0, 4);
              repeat (len) begin
                do b = BYTE_W'($urandom_range(0, 255));
                while (b == CH_QUOTE || b == CH_COMMA || b == CH_CR || b == CH_LF);
                text_bytes = {text_bytes, b};
              end
            end
          end
          if (r < rows - 1 || $urandom_range(0, 1) == 1) begin
            text_bytes = {text_bytes, CH_CR};
            text_bytes = {text_bytes, CH_LF};
          end
        end
        if (kind == 1 && text_bytes.size() > 0) begin
          text_bytes[$urandom_range(0, text_bytes.size() - 1)] = odd_byte();
        end
        if (kind == 2) text_bytes = {text_bytes, CH_CR};
      end
      if (text_bytes.size() == 0) text_bytes = {text_bytes, 8'h61};
      tx_calm = ($urandom_range(0, 3) == 0);
      foreach (text_bytes[i]) begin
        feed_byte(text_bytes[i], i == text_bytes.size() - 1, 0, '0);
      end
      sent += text_bytes.size();
      text_idx++;
      if (text_idx % 25 == 12) drain_wait();
    end

    drain_wait();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && due_tokens.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/csvt_pkg.sv
rtl/core/csvt_ifs.sv
rtl/core/csvt_fsm.sv
rtl/core/csv_byte_tokenizer.sv
tb/testbench.sv
